FILE: hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 engine.
package rc4_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int BYTE_W        = 8;
  localparam int KEY_REG_W     = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_IDX_W     = 4;
  localparam int CFG_IDX_W     = 2;

  // command codes
  localparam logic CMD_INIT  = 1'b0;
  localparam logic CMD_CRYPT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_in;
  } rc4_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              not_keyed;
  } rc4_out_t;

endpackage

FILE: hw/rtl/rc4_stream_cipher.sv
// RC4 engine top level: key registers, key byte select and the sequencer core.
// Init request: busy for 256 table fill writes, then 256 swap steps (two reads,
//   two writes each on the one table RAM); it gives no result.
// Crypt request: dependent table reads and swap writes, then the result; no new
//   request until it is put out. Before keying, a not-keyed result, no table steps.
// Reset (sync, high): engine idle and not keyed, key registers 0/0, length 16.
//   The table holds no reset value; init writes every entry before use.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_data,
  // request channel
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rc4_in_t              item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output rc4_out_t             result
);

  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [KEY_REG_W-1:0] key_low;
  logic [KEY_REG_W-1:0] key_high;
  logic [KEY_LEN_W-1:0] key_length;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [BYTE_W-1:0]    key_byte;
  logic [2*KEY_REG_W-1:0] key_all;

  // register file; out-of-list index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= KEY_LEN_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero length acts as one byte, long keys clip to the supported maximum
  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  // byte n of the key sits at bits 8n+7..8n of {high, low}
  assign key_all  = {key_high, key_low};
  assign key_byte = key_all[{key_idx, 3'b000} +: BYTE_W];

  rc4_core u_core (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .key_len     (eff_len),
    .key_idx     (key_idx),
    .key_byte    (key_byte)
  );

endmodule

FILE: hw/rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rc4_core.sv
// RC4 sequencer: key schedule and keystream steps over one state table RAM.
module rc4_core
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rc4_in_t              item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rc4_out_t             result,
  input  logic [KEY_LEN_W-1:0] key_len,
  output logic [KEY_IDX_W-1:0] key_idx,
  input  logic [BYTE_W-1:0]    key_byte
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL,
    S_K_RD_T, S_K_RD_J, S_K_WR_T, S_K_WR_J,
    S_C_RD_I, S_C_RD_J, S_C_WR_I, S_C_WR_J, S_C_KS,
    S_PUT
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] cnt;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] din;
  logic [BYTE_W-1:0] res_data;
  logic              res_nk;
  logic              keyed;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [BYTE_W-1:0] i_next;
  logic [BYTE_W-1:0] j_ksa_next;
  logic [BYTE_W-1:0] j_prga_next;
  logic [BYTE_W-1:0] ks_addr;
  logic [BYTE_W-1:0] ks;
  logic              key_wrap;

  assign i_next      = idx_i + 8'd1;
  assign j_ksa_next  = idx_j + ram_rdata + key_byte;
  assign j_prga_next = idx_j + ram_rdata;
  assign ks_addr     = si + sj;
  // table[j] was written in the same cycle as the keystream read
  assign ks          = (ks_addr == idx_j) ? si : ram_rdata;
  assign key_wrap    = ({1'b0, key_idx} + 5'd1) == key_len;
  assign item_ready  = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = cnt;
    ram_raddr = cnt;
    case (state)
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_K_RD_J: begin
        ram_raddr = j_ksa_next;
      end
      S_K_WR_T: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_K_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = idx_j;
        ram_wdata = si;
      end
      S_C_RD_I: begin
        ram_raddr = i_next;
      end
      S_C_RD_J: begin
        ram_raddr = j_prga_next;
      end
      S_C_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i;
        ram_wdata = ram_rdata;
      end
      S_C_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = idx_j;
        ram_wdata = si;
        ram_raddr = ks_addr;
      end
      default: begin
      end
    endcase
  end

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      idx_i        <= '0;
      idx_j        <= '0;
      key_idx      <= '0;
      keyed        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // S_PUT drives result_valid itself
      if (result_valid && result_ready && state != S_PUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            din <= item.data_in;
            if (item.cmd == CMD_INIT) begin
              cnt   <= '0;
              state <= S_FILL;
            end else if (!keyed) begin
              res_data <= '0;
              res_nk   <= 1'b1;
              state    <= S_PUT;
            end else begin
              state <= S_C_RD_I;
            end
          end
        end
        S_FILL: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'(TABLE_ENTRIES - 1)) begin
            idx_j   <= '0;
            key_idx <= '0;
            state   <= S_K_RD_T;
          end
        end
        S_K_RD_T: begin
          state <= S_K_RD_J;
        end
        S_K_RD_J: begin
          si    <= ram_rdata;
          idx_j <= j_ksa_next;
          state <= S_K_WR_T;
        end
        S_K_WR_T: begin
          state <= S_K_WR_J;
        end
        S_K_WR_J: begin
          cnt     <= cnt + 8'd1;
          key_idx <= key_wrap ? '0 : key_idx + 4'd1;
          if (cnt == 8'(TABLE_ENTRIES - 1)) begin
            idx_i <= '0;
            idx_j <= '0;
            keyed <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_K_RD_T;
          end
        end
        S_C_RD_I: begin
          idx_i <= i_next;
          state <= S_C_RD_J;
        end
        S_C_RD_J: begin
          si    <= ram_rdata;
          idx_j <= j_prga_next;
          state <= S_C_WR_I;
        end
        S_C_WR_I: begin
          sj    <= ram_rdata;
          state <= S_C_WR_J;
        end
        S_C_WR_J: begin
          state <= S_C_KS;
        end
        S_C_KS: begin
          res_data <= din ^ ks;
          res_nk   <= 1'b0;
          state    <= S_PUT;
        end
        S_PUT: begin
          if (!result_valid || result_ready) begin
            result.data_out  <= res_data;
            result.not_keyed <= res_nk;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/rc4_checker.sv
// Port-level checks for the RC4 engine, bound to the top level.
module rc4_checker
  import rc4_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     item_valid,
  input logic     item_ready,
  input rc4_in_t  item,
  input logic     result_valid,
  input logic     result_ready,
  input rc4_out_t result
);

  // a pending result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // engine goes busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("engine ready right after accepting a request");

  // not-keyed results carry zero data
  a_not_keyed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.not_keyed |-> result.data_out == '0)
    else $error("not-keyed result with nonzero data");

  // an init request taken while no result is pending still has none partway through its schedule
  a_init_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd == CMD_INIT && !result_valid |=> ##8 !result_valid)
    else $error("result appeared during key schedule");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);

FILE: sim/rc4_stream_cipher_tb.sv
// Self-checking testbench for the RC4 engine: queued requests, clocked driver and monitor.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam int KEY_BYTES_MAX    = 16;
  localparam int INIT_BUSY_CYCLES = 1280;
  localparam int SETTLE_CYCLES    = INIT_BUSY_CYCLES + 120;
  localparam int RUN_LIMIT        = 1500000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int REPORT_MAX       = 10;
  // index past the last key register; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    rc4_in_t req;
    bit      drain_first;  // hold this request until every result is back
  } backlog_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_REG_W-1:0] cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  rc4_in_t              item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  rc4_out_t             result;

  rc4_stream_cipher #(.MAX_KEY_BYTES(KEY_BYTES_MAX)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: key registers, permutation table, indices
  logic [KEY_REG_W-1:0] key_lo_r  = '0;
  logic [KEY_REG_W-1:0] key_hi_r  = '0;
  logic [KEY_LEN_W-1:0] key_len_r = 5'd16;
  logic [BYTE_W-1:0]    perm [TABLE_ENTRIES];
  logic [BYTE_W-1:0]    idx_i = '0;
  logic [BYTE_W-1:0]    idx_j = '0;
  bit                   keyed_q = 1'b0;

  backlog_t req_backlog [$];
  rc4_out_t due_results [$];
  backlog_t next_req;

  int send_idle = 0;
  int recv_idle = 0;
  int items_queued = 0;
  int mismatches = 0;
  int results_checked = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int cycle_cnt = 0;

  function automatic logic [BYTE_W-1:0] key_byte(int n);
    logic [KEY_REG_W-1:0] word;
    word = (n < 8) ? key_lo_r : key_hi_r;
    return word[(n % 8) * 8 +: 8];
  endfunction

  task automatic schedule_key();
    int                klen;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] tmp;
    klen = key_len_r;
    if (klen == 0) klen = 1;
    if (klen > KEY_BYTES_MAX) klen = KEY_BYTES_MAX;
    for (int t = 0; t < TABLE_ENTRIES; t++) perm[t] = BYTE_W'(t);
    acc = '0;
    for (int t = 0; t < TABLE_ENTRIES; t++) begin
      acc = acc + perm[t] + key_byte(t % klen);
      tmp = perm[t];
      perm[t] = perm[acc];
      perm[acc] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
    keyed_q = 1'b1;
  endtask

  function automatic logic [BYTE_W-1:0] next_keystream();
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] sum_ij;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    tmp = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = tmp;
    sum_ij = perm[idx_i] + perm[idx_j];
    return perm[sum_ij];
  endfunction

  task automatic cipher_step(rc4_in_t req);
    rc4_out_t r;
    if (req.cmd == CMD_INIT) begin
      schedule_key();
    end else begin
      if (!keyed_q) begin
        r.data_out  = '0;
        r.not_keyed = 1'b1;
      end else begin
        r.data_out  = req.data_in ^ next_keystream();
        r.not_keyed = 1'b0;
      end
      due_results.push_back(r);
    end
  endtask

  // driver: offers queued requests, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) cipher_step(item);
      if (!item_valid || item_ready) begin
        if (req_backlog.size() != 0 &&
            !(req_backlog[0].drain_first && due_results.size() != 0) &&
            $urandom_range(99) >= send_idle) begin
          next_req = req_backlog.pop_front();
          item <= next_req.req;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: data_out=%02h not_keyed=%0d",
                     result.data_out, result.not_keyed);
        end else begin
          rc4_out_t want;
          want = due_results.pop_front();
          if (result.data_out !== want.data_out || result.not_keyed !== want.not_keyed) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch #%0d: data_out exp %02h got %02h, not_keyed exp %0d got %0d",
                       results_checked, want.data_out, result.data_out,
                       want.not_keyed, result.not_keyed);
          end
        end
        results_checked++;
      end
      // one long back-pressure stretch while requests are still queued
      if (!long_hold_done && results_checked >= 300 && req_backlog.size() > 8) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_req(logic cmd, logic [BYTE_W-1:0] data, bit drain);
    backlog_t b;
    b.req.cmd     = cmd;
    b.req.data_in = data;
    b.drain_first = drain;
    req_backlog.push_back(b);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_REG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KEY_LOW:  key_lo_r = value;
      REG_KEY_HIGH: key_hi_r = value;
      REG_KEY_LEN:  key_len_r = value[KEY_LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // engine idle: nothing queued or offered, every result back, init finished
  task automatic settle();
    while (req_backlog.size() != 0 || item_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_session();
    bit                   rekey;
    int                   n_crypt;
    logic [KEY_LEN_W-1:0] len;
    settle();
    rekey = ($urandom_range(3) != 0);
    // without rekey these writes only matter at the next init
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    if ($urandom_range(1) == 0) write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    case ($urandom_range(7))
      0:       len = 5'd0;
      1:       len = 5'd16;
      2:       len = 5'd1;
      3:       len = KEY_LEN_W'($urandom_range(31, 17));
      default: len = KEY_LEN_W'($urandom_range(16, 1));
    endcase
    write_reg(REG_KEY_LEN, KEY_REG_W'(len));
    if ($urandom_range(9) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    n_crypt = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(60, 10);
    if (rekey) queue_req(CMD_INIT, BYTE_W'($urandom_range(255)), 1'b0);
    repeat (n_crypt) begin
      if ($urandom_range(39) == 0) queue_req(CMD_INIT, BYTE_W'($urandom_range(255)), 1'b0);
      queue_req(CMD_CRYPT, BYTE_W'($urandom_range(255)), ($urandom_range(49) == 0));
    end
  endtask

  task automatic random_phase(int n_items);
    int stop_at;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) random_session();
  endtask

  initial begin
    send_idle = 37;
    recv_idle = 86;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // crypt before any key schedule
    queue_req(CMD_CRYPT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'hFF, 1'b0);
    // reset registers: all-zero key, length 16
    queue_req(CMD_INIT, 8'h00, 1'b1);
    queue_req(CMD_CRYPT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'hFF, 1'b0);
    settle();
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LEN, KEY_REG_W'(16));
    queue_req(CMD_INIT, 8'hFF, 1'b0);
    queue_req(CMD_CRYPT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'hFF, 1'b0);
    queue_req(CMD_CRYPT, 8'h5A, 1'b0);
    settle();
    // unused index, then zero length (acts as one byte)
    write_reg(REG_UNUSED, '1);
    write_reg(REG_KEY_LEN, KEY_REG_W'(0));
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    queue_req(CMD_INIT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'hA5, 1'b0);
    queue_req(CMD_CRYPT, 8'h3C, 1'b0);
    settle();
    // length above the limit saturates
    write_reg(REG_KEY_LEN, KEY_REG_W'(31));
    write_reg(REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
    queue_req(CMD_INIT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'h01, 1'b0);
    queue_req(CMD_CRYPT, 8'h80, 1'b0);
    settle();
    // single key byte, then back-to-back init mid-stream
    write_reg(REG_KEY_LEN, KEY_REG_W'(1));
    write_reg(REG_KEY_LOW, 64'h80);
    queue_req(CMD_INIT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'hFF, 1'b0);
    queue_req(CMD_INIT, 8'h00, 1'b0);
    queue_req(CMD_INIT, 8'h00, 1'b0);
    queue_req(CMD_CRYPT, 8'h00, 1'b0);
    settle();
    // key write without init must not disturb the running keystream
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    queue_req(CMD_CRYPT, 8'h11, 1'b0);
    queue_req(CMD_CRYPT, 8'hEE, 1'b0);

    random_phase(600);
    settle();
    send_idle = 86;
    recv_idle = 37;
    random_phase(600);
    settle();
    send_idle = 0;
    recv_idle = 0;
    random_phase(500);

    while (req_backlog.size() != 0 || item_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
